### rtl/jads_pkg.sv
// shared widths, constants, register indexes and pipeline types of the joystick axis scaler
package jads_pkg;

    localparam int SLOT_W      = 2;
    localparam int RAW_W       = 12;
    localparam int CAL_W       = 12;
    localparam int PCT_W       = 7;
    localparam int CFG_W       = 37;
    localparam int CFG_IDX_W   = 3;
    localparam int OUT_W       = 16;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_USER_W  = 3;
    localparam int Q_W         = 15;
    localparam int NUM_W       = CAL_W + Q_W;
    localparam int PROD_W      = CAL_W + PCT_W;
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 26;
    localparam int RPROD_W     = PROD_W + RECIP_W;

    localparam int CAL_REGS     = 4;
    localparam int DEF_ADC_BITS = 12;
    localparam int DEF_NUM_AXES = 4;

    // calibration word layout
    localparam int CAL_MIN_LSB     = 0;
    localparam int CAL_MAX_LSB     = 12;
    localparam int CAL_REST_LSB    = 24;
    localparam int CAL_PRESENT_BIT = 36;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 3'd0;
    localparam int                   REG_CAL_BASE = 1;

    // ceil(2^26 / 100): floor(x / 100) = (x * RECIP_100) >> 26 for x below 2^19
    localparam logic [RECIP_W-1:0] RECIP_100 = 20'd671089;
    localparam logic [PCT_W-1:0]   PCT_MAX   = 7'd99;
    localparam logic [PCT_W-1:0]   PCT_RESET = 7'd8;
    localparam logic [OUT_W-1:0]   OUT_MAX   = 16'd32767;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              pass;
        logic [RAW_W-1:0]  raw;
        logic              neg;
        logic              zero;
        logic              sat;
    } t_ctl;

endpackage

### rtl/jads_front.sv
// front stages: calibration lookup, side travel, dead zone and divider operands
module jads_front
    import jads_pkg::*;
#(
    parameter int  ADC_BITS = DEF_ADC_BITS,
    parameter int  NUM_AXES = DEF_NUM_AXES,
    localparam int NumCal   = (NUM_AXES < CAL_REGS) ? NUM_AXES : CAL_REGS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [RAW_W-1:0]  i_raw,
    input  logic [PCT_W-1:0]  i_pct,
    input  logic [CFG_W-1:0]  i_cal [NumCal],
    output logic              o_valid,
    input  logic              i_ready,
    output t_ctl              o_ctl,
    output logic [NUM_W-1:0]  o_num,
    output logic [CAL_W-1:0]  o_den
);

    localparam int               MaskBits = (ADC_BITS < RAW_W) ? ADC_BITS : RAW_W;
    localparam logic [RAW_W-1:0] RawMask  = RAW_W'((64'd1 << MaskBits) - 64'd1);

    logic en1, en2, en3, en4;

    logic r1_valid, r2_valid, r3_valid, r4_valid;
    t_ctl r1_ctl, r2_ctl, r3_ctl, r4_ctl;
    logic [CAL_W-1:0]   r1_mag, r2_mag, r3_mag;
    logic [CAL_W-1:0]   r1_span, r2_span, r3_span;
    logic               r1_nospan, r2_nospan, r3_nospan;
    logic [PCT_W-1:0]   r1_pct;
    logic [PROD_W-1:0]  r2_prod;
    logic [RPROD_W-1:0] r3_rprod;
    logic [NUM_W-1:0]   r4_num;
    logic [CAL_W-1:0]   r4_den;

    // stage 1 combinational
    logic              found;
    logic [CFG_W-1:0]  cal;
    logic [RAW_W-1:0]  raw_m;
    logic [CAL_W-1:0]  cmin, cmax, crest;
    t_ctl              n1_ctl;
    logic [CAL_W-1:0]  n1_mag, n1_span;
    logic              n1_nospan;
    logic [PCT_W-1:0]  n1_pct;

    // stage 4 combinational
    logic [CAL_W-1:0]  dz, numv;
    t_ctl              n4_ctl;
    logic [NUM_W-1:0]  n4_num;
    logic [CAL_W-1:0]  n4_den;

    assign en4     = !r4_valid || i_ready;
    assign en3     = !r3_valid || en4;
    assign en2     = !r2_valid || en3;
    assign en1     = !r1_valid || en2;
    assign o_ready = en1;

    always_comb begin
        found = 1'b0;
        cal   = '0;
        for (int k = 0; k < NumCal; k++) begin
            if (i_slot == SLOT_W'(k)) begin
                found = 1'b1;
                cal   = i_cal[k];
            end
        end
    end

    always_comb begin
        raw_m  = i_raw & RawMask;
        cmin   = cal[CAL_MIN_LSB  +: CAL_W];
        cmax   = cal[CAL_MAX_LSB  +: CAL_W];
        crest  = cal[CAL_REST_LSB +: CAL_W];

        n1_ctl      = '0;
        n1_ctl.slot = i_slot;
        n1_ctl.pass = !(found && cal[CAL_PRESENT_BIT]);
        n1_ctl.raw  = raw_m;
        n1_ctl.neg  = raw_m < crest;

        if (n1_ctl.neg) begin
            n1_mag    = crest - raw_m;
            n1_span   = crest - cmin;
            n1_nospan = cmin >= crest;
        end else begin
            n1_mag    = raw_m - crest;
            n1_span   = cmax - crest;
            n1_nospan = cmax <= crest;
        end
        n1_pct = (i_pct > PCT_MAX) ? PCT_MAX : i_pct;
    end

    always_comb begin
        dz     = r3_rprod[RECIP_SHIFT +: CAL_W];
        numv   = r3_mag - dz;
        n4_ctl = r3_ctl;
        // inside the dead zone, or a side with no travel, gives zero
        n4_ctl.zero = r3_nospan || (r3_mag < dz);
        n4_ctl.sat  = r3_mag >= r3_span;
        // numv * 32767 as a shift and subtract
        n4_num = {numv, {Q_W{1'b0}}} - {{Q_W{1'b0}}, numv};
        n4_den = r3_span - dz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (en1) r1_valid <= i_valid;
            if (en2) r2_valid <= r1_valid;
            if (en3) r3_valid <= r2_valid;
            if (en4) r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_ctl    <= n1_ctl;
            r1_mag    <= n1_mag;
            r1_span   <= n1_span;
            r1_nospan <= n1_nospan;
            r1_pct    <= n1_pct;
        end
        if (en2) begin
            r2_ctl    <= r1_ctl;
            r2_mag    <= r1_mag;
            r2_span   <= r1_span;
            r2_nospan <= r1_nospan;
            r2_prod   <= PROD_W'(r1_span) * PROD_W'(r1_pct);
        end
        if (en3) begin
            r3_ctl    <= r2_ctl;
            r3_mag    <= r2_mag;
            r3_span   <= r2_span;
            r3_nospan <= r2_nospan;
            r3_rprod  <= RPROD_W'(r2_prod) * RPROD_W'(RECIP_100);
        end
        if (en4) begin
            r4_ctl <= n4_ctl;
            r4_num <= n4_num;
            r4_den <= n4_den;
        end
    end

    assign o_valid = r4_valid;
    assign o_ctl   = r4_ctl;
    assign o_num   = r4_num;
    assign o_den   = r4_den;

endmodule

### rtl/jads_div.sv
// pipelined restoring divider, one quotient bit per stage
module jads_div
    import jads_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_ctl             i_ctl,
    input  logic [NUM_W-1:0] i_num,
    input  logic [CAL_W-1:0] i_den,
    output logic             o_valid,
    input  logic             i_ready,
    output t_ctl             o_ctl,
    output logic [Q_W-1:0]   o_q
);

    logic [Q_W:0]     en;
    logic             r_valid [Q_W];
    logic [CAL_W-1:0] r_rem   [Q_W];
    logic [Q_W-1:0]   r_lo    [Q_W];
    logic [Q_W-1:0]   r_q     [Q_W];
    logic [CAL_W-1:0] r_den   [Q_W];
    t_ctl             r_ctl   [Q_W];

    logic             n_valid [Q_W];
    logic [CAL_W-1:0] n_rem   [Q_W];
    logic [Q_W-1:0]   n_lo    [Q_W];
    logic [Q_W-1:0]   n_q     [Q_W];
    logic [CAL_W-1:0] n_den   [Q_W];
    t_ctl             n_ctl   [Q_W];

    always_comb begin
        en[Q_W] = i_ready;
        for (int k = Q_W - 1; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
    end

    assign o_ready = en[0];

    always_comb begin
        logic [CAL_W-1:0] rem_in;
        logic [Q_W-1:0]   lo_in;
        logic [Q_W-1:0]   q_in;
        logic [CAL_W-1:0] den_in;
        t_ctl             ctl_in;
        logic             v_in;
        logic [CAL_W:0]   trial;
        logic             ge;
        for (int k = 0; k < Q_W; k++) begin
            if (k == 0) begin
                // the numerator's top bits are already below the divisor
                rem_in = i_num[NUM_W-1 -: CAL_W];
                lo_in  = i_num[Q_W-1:0];
                q_in   = '0;
                den_in = i_den;
                ctl_in = i_ctl;
                v_in   = i_valid;
            end else begin
                rem_in = r_rem[k-1];
                lo_in  = r_lo[k-1];
                q_in   = r_q[k-1];
                den_in = r_den[k-1];
                ctl_in = r_ctl[k-1];
                v_in   = r_valid[k-1];
            end
            trial      = {rem_in, lo_in[Q_W-1]};
            ge         = trial >= {1'b0, den_in};
            n_rem[k]   = ge ? CAL_W'(trial - {1'b0, den_in}) : trial[CAL_W-1:0];
            n_lo[k]    = {lo_in[Q_W-2:0], 1'b0};
            n_q[k]     = {q_in[Q_W-2:0], ge};
            n_den[k]   = den_in;
            n_ctl[k]   = ctl_in;
            n_valid[k] = v_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < Q_W; k++) r_valid[k] <= 1'b0;
        end else begin
            for (int k = 0; k < Q_W; k++) begin
                if (en[k]) r_valid[k] <= n_valid[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < Q_W; k++) begin
            if (en[k]) begin
                r_rem[k] <= n_rem[k];
                r_lo[k]  <= n_lo[k];
                r_q[k]   <= n_q[k];
                r_den[k] <= n_den[k];
                r_ctl[k] <= n_ctl[k];
            end
        end
    end

    assign o_valid = r_valid[Q_W-1];
    assign o_ctl   = r_ctl[Q_W-1];
    assign o_q     = r_q[Q_W-1];

endmodule

### rtl/joystick_axis_deadzone_scaler.sv
// top level: configuration registers, front stages, divider and output register
//
// Centers, dead-zones and scales raw joystick ADC samples per axis.
// Input stream: s_axis_tdata carries the raw sample, s_axis_tuser the axis slot.
// Output stream: m_axis_tdata carries the signed result, m_axis_tuser the slot
// and a pass-through flag (set when the axis is not marked present, the raw
// sample then comes back unchanged).
// Configuration: one write request per cycle on i_cfg_*, always accepted;
// index 0 is the dead zone percent, indexes 1 to 4 the axis calibration words.
// Write configuration only while no sample is in flight.
// Pipeline: four front stages (lookup, two multiplier stages, operand prep),
// fifteen divider stages giving one quotient bit each, and the output register.
// Throughput: one sample per cycle while the receiver is ready.
// Reset clears all in-flight requests, sets the dead zone to 8 percent and
// marks every axis absent.
// When the receiver stalls, the result holds on the output and each stage
// keeps its item; bubbles still fill, so input is taken until the pipe is full.
module joystick_axis_deadzone_scaler
    import jads_pkg::*;
#(
    parameter int ADC_BITS = DEF_ADC_BITS,
    parameter int NUM_AXES = DEF_NUM_AXES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [11:0] raw_value
    input  logic [SLOT_W-1:0]     s_axis_tuser,   // [1:0] axis_slot
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,   // [15:0] scaled_value
    output logic [OUT_USER_W-1:0] m_axis_tuser,   // [1:0] axis_slot_out, [2] passed_through
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    localparam int NumCal = (NUM_AXES < CAL_REGS) ? NUM_AXES : CAL_REGS;

    logic [PCT_W-1:0] r_pct;
    logic [CFG_W-1:0] r_cal [NumCal];

    logic             fr_valid, fr_ready;
    t_ctl             fr_ctl;
    logic [NUM_W-1:0] fr_num;
    logic [CAL_W-1:0] fr_den;

    logic             dv_valid, dv_ready;
    t_ctl             dv_ctl;
    logic [Q_W-1:0]   dv_q;

    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;
    logic [OUT_W-1:0]      n_out_data;
    logic [OUT_W-1:0]      mag;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pct <= PCT_RESET;
            for (int k = 0; k < NumCal; k++) r_cal[k] <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_DEADZONE) r_pct <= i_cfg_data[PCT_W-1:0];
            for (int k = 0; k < NumCal; k++) begin
                if (i_cfg_index == CFG_IDX_W'(REG_CAL_BASE + k)) r_cal[k] <= i_cfg_data;
            end
        end
    end

    jads_front #(
        .ADC_BITS (ADC_BITS),
        .NUM_AXES (NUM_AXES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_slot  (s_axis_tuser),
        .i_raw   (s_axis_tdata[RAW_W-1:0]),
        .i_pct   (r_pct),
        .i_cal   (r_cal),
        .o_valid (fr_valid),
        .i_ready (fr_ready),
        .o_ctl   (fr_ctl),
        .o_num   (fr_num),
        .o_den   (fr_den)
    );

    jads_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_ctl   (fr_ctl),
        .i_num   (fr_num),
        .i_den   (fr_den),
        .o_valid (dv_valid),
        .i_ready (dv_ready),
        .o_ctl   (dv_ctl),
        .o_q     (dv_q)
    );

    assign dv_ready = !r_out_valid || m_axis_tready;

    always_comb begin
        priority if (dv_ctl.zero) begin
            mag = '0;
        end else if (dv_ctl.sat) begin
            mag = OUT_MAX;
        end else begin
            mag = {1'b0, dv_q};
        end

        if (dv_ctl.pass) begin
            n_out_data = {{(OUT_W-RAW_W){1'b0}}, dv_ctl.raw};
        end else if (dv_ctl.neg) begin
            n_out_data = -mag;
        end else begin
            n_out_data = mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (dv_ready) begin
            r_out_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dv_ready) begin
            r_out_data <= n_out_data;
            r_out_user <= {dv_ctl.pass, dv_ctl.slot};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

### rtl/jads_checker.sv
// port-level checks of the joystick axis scaler, bound to the top level
module jads_checker
    import jads_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_W-1:0]      m_axis_tdata,
    input logic [OUT_USER_W-1:0] m_axis_tuser
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // nothing in flight survives reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a passed-through sample never exceeds the raw field
    a_pass_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tdata[OUT_W-1:RAW_W] == '0)
        else $error("pass-through value wider than the raw sample");

    // scaled output stays within plus or minus full scale
    a_scaled_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tdata != ~OUT_MAX)
        else $error("scaled value out of range");

endmodule

bind joystick_axis_deadzone_scaler jads_checker u_jads_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### test/testbench.sv
// self-checking testbench for the joystick axis dead-zone scaler
module testbench;
    import jads_pkg::*;

    localparam int FULL_SCALE   = 32767;
    localparam int PIPE_LATENCY = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_ITEMS  = 285;
    localparam int RAW_TOP      = (1 << RAW_W) - 1;
    // first index past the calibration words, not mapped to any register
    localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(REG_CAL_BASE + CAL_REGS);

    typedef struct packed {
        logic [SLOT_W-1:0]       slot;
        logic signed [OUT_W-1:0] value;
        logic                    pass;
    } t_axis_result;

    typedef enum logic {ROW_CFG, ROW_SAMPLE} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_W-1:0]      data;
        logic [SLOT_W-1:0]     slot;
        logic [RAW_W-1:0]      raw;
        bit                    typed;
        t_axis_result          want;
    } t_stim_row;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [11:0] raw_value
    logic [SLOT_W-1:0]     s_axis_tuser  = '0;   // [1:0] axis_slot
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;         // [15:0] scaled_value
    logic [OUT_USER_W-1:0] m_axis_tuser;         // [1:0] axis_slot_out, [2] passed_through
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_W-1:0]      i_cfg_data    = '0;

    // mirror of the register file
    logic [PCT_W-1:0] dz_pct;
    logic [CFG_W-1:0] cal_mirror [CAL_REGS];

    t_axis_result pending_results [$];
    int           errors        = 0;
    int           results_seen  = 0;
    int           samples_sent  = 0;
    int           cfg_writes    = 0;
    int           cycle_count   = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;

    joystick_axis_deadzone_scaler u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // outputs are stable at the falling edge; a request seen here completes
    // at the next rising edge
    always @(negedge i_clk) begin
        t_axis_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result: slot %0d value %0d pass %0d",
                       m_axis_tuser[1:0], $signed(m_axis_tdata), m_axis_tuser[2]);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser[1:0] !== want.slot) begin
                    $error("axis_slot_out: expected %0d, got %0d", want.slot,
                           m_axis_tuser[1:0]);
                    errors++;
                end
                if (m_axis_tdata !== want.value) begin
                    $error("scaled_value: expected %0d, got %0d", want.value,
                           $signed(m_axis_tdata));
                    errors++;
                end
                if (m_axis_tuser[2] !== want.pass) begin
                    $error("passed_through: expected %0d, got %0d", want.pass,
                           m_axis_tuser[2]);
                    errors++;
                end
            end
        end
    end

    function automatic t_axis_result scale_sample(input logic [SLOT_W-1:0] slot,
                                                  input logic [RAW_W-1:0] raw);
        logic [CFG_W-1:0] cal;
        t_axis_result     r;
        int               lo, hi, rest, d, span, pct, dz, mag;
        longint           q;
        cal     = cal_mirror[slot];
        r.slot  = slot;
        r.pass  = 1'b0;
        r.value = '0;
        if (!cal[CAL_PRESENT_BIT]) begin
            r.value = OUT_W'(raw);
            r.pass  = 1'b1;
            return r;
        end
        lo   = int'(cal[CAL_MIN_LSB +: CAL_W]);
        hi   = int'(cal[CAL_MAX_LSB +: CAL_W]);
        rest = int'(cal[CAL_REST_LSB +: CAL_W]);
        d    = int'(raw) - rest;
        span = (d < 0) ? rest - lo : hi - rest;
        if (span > 0) begin
            pct = (dz_pct > PCT_MAX) ? int'(PCT_MAX) : int'(dz_pct);
            dz  = span * pct / 100;
            if (!(d > -dz && d < dz)) begin
                mag = (d < 0) ? -d : d;
                q   = longint'(mag - dz) * FULL_SCALE / longint'(span - dz);
                if (q > FULL_SCALE)
                    q = FULL_SCALE;
                r.value = OUT_W'((d < 0) ? -q : q);
            end
        end
        return r;
    endfunction

    function automatic logic [CFG_W-1:0] cal_word(input bit present, input int rest,
                                                  input int hi, input int lo);
        return {present, CAL_W'(rest), CAL_W'(hi), CAL_W'(lo)};
    endfunction

    function automatic logic [CFG_W-1:0] random_cal();
        int lo, hi, rest;
        case ($urandom_range(0, 9))
            0: return {1'b0, (CFG_W-1)'({$urandom, $urandom})};
            // arbitrary fields, often a side with no travel
            1: return {1'b1, (CFG_W-1)'({$urandom, $urandom})};
            2: return $urandom_range(0, 1) ? cal_word(1, 0, RAW_TOP, 0)
                                           : cal_word(1, RAW_TOP, RAW_TOP, 0);
            3: begin
                rest = $urandom_range(10, RAW_TOP - 10);
                return cal_word(1, rest, rest + $urandom_range(1, 10),
                                rest - $urandom_range(1, 10));
            end
            default: begin
                lo   = $urandom_range(0, 1500);
                hi   = $urandom_range(2600, RAW_TOP);
                rest = $urandom_range(lo + 1, hi - 1);
                return cal_word(1, rest, hi, lo);
            end
        endcase
    endfunction

    function automatic t_stim_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] data);
        t_stim_row row;
        row.kind  = ROW_CFG;
        row.idx   = idx;
        row.data  = data;
        row.slot  = '0;
        row.raw   = '0;
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    function automatic t_stim_row smp_row(input int slot, input int raw, input bit typed,
                                          input int value, input bit pass);
        t_stim_row row;
        row.kind       = ROW_SAMPLE;
        row.idx        = '0;
        row.data       = '0;
        row.slot       = SLOT_W'(slot);
        row.raw        = RAW_W'(raw);
        row.typed      = typed;
        row.want.slot  = SLOT_W'(slot);
        row.want.value = OUT_W'(value);
        row.want.pass  = pass;
        return row;
    endfunction

    // call at a rising edge; returns at the edge that took the request
    task automatic send_sample(input logic [SLOT_W-1:0] slot, input logic [RAW_W-1:0] raw,
                               input t_axis_result want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'(raw);
        s_axis_tuser  <= slot;
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
        pending_results.push_back(want);
        samples_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == REG_DEADZONE)
            dz_pct = data[PCT_W-1:0];
        else if (idx >= REG_CAL_BASE && idx < REG_CAL_BASE + CAL_REGS)
            cal_mirror[idx - REG_CAL_BASE] = data;
        cfg_writes++;
        @(posedge i_clk);
    endtask

    initial begin
        t_stim_row        directed [$];
        t_stim_row        row;
        t_axis_result     want;
        logic [SLOT_W-1:0] slot;
        logic [CFG_W-1:0] cal;
        int               raw, rest, span, side, dz;

        dz_pct = PCT_RESET;
        foreach (cal_mirror[i])
            cal_mirror[i] = '0;

        // all axes absent after reset
        directed.push_back(smp_row(0, 0, 1, 0, 1));
        directed.push_back(smp_row(3, RAW_TOP, 1, RAW_TOP, 1));
        directed.push_back(cfg_row(REG_CAL_BASE + 0, cal_word(1, 2048, RAW_TOP, 0)));
        directed.push_back(smp_row(0, 0, 1, -FULL_SCALE, 0));
        directed.push_back(smp_row(0, RAW_TOP, 1, FULL_SCALE, 0));
        directed.push_back(smp_row(0, 2048, 1, 0, 0));
        // dead-zone edges around rest
        directed.push_back(smp_row(0, 2211, 0, 0, 0));
        directed.push_back(smp_row(0, 2210, 0, 0, 0));
        directed.push_back(smp_row(0, 1885, 0, 0, 0));
        directed.push_back(smp_row(0, 1000, 0, 0, 0));
        directed.push_back(cfg_row(REG_CAL_BASE + 1, cal_word(1, 2000, 3000, 1000)));
        // beyond min and max saturates
        directed.push_back(smp_row(1, 0, 1, -FULL_SCALE, 0));
        directed.push_back(smp_row(1, RAW_TOP, 1, FULL_SCALE, 0));
        directed.push_back(smp_row(1, 2600, 0, 0, 0));
        // no travel on either side
        directed.push_back(cfg_row(REG_CAL_BASE + 2, cal_word(1, 2000, 2000, 2500)));
        directed.push_back(smp_row(2, 100, 1, 0, 0));
        directed.push_back(smp_row(2, 3000, 1, 0, 0));
        directed.push_back(smp_row(2, 2000, 1, 0, 0));
        // fields set but present bit clear
        directed.push_back(cfg_row(REG_CAL_BASE + 3, cal_word(0, RAW_TOP, RAW_TOP, RAW_TOP)));
        directed.push_back(smp_row(3, 'hABC, 1, 'hABC, 1));
        directed.push_back(cfg_row(REG_DEADZONE, '0));
        directed.push_back(smp_row(0, 2049, 0, 0, 0));
        directed.push_back(smp_row(0, 2047, 0, 0, 0));
        // dead zone above 99 percent clamps to 99
        directed.push_back(cfg_row(REG_DEADZONE, CFG_W'(127)));
        directed.push_back(smp_row(0, RAW_TOP, 1, FULL_SCALE, 0));
        directed.push_back(smp_row(0, 2100, 1, 0, 0));
        directed.push_back(smp_row(1, 1005, 0, 0, 0));
        directed.push_back(cfg_row(REG_DEADZONE, CFG_W'(PCT_MAX)));
        directed.push_back(smp_row(1, 2990, 0, 0, 0));
        // unmapped index must leave every register alone
        directed.push_back(cfg_row(REG_NONE, '1));
        directed.push_back(smp_row(0, 500, 0, 0, 0));
        directed.push_back(cfg_row(REG_CAL_BASE + 3, cal_word(1, RAW_TOP, RAW_TOP, 0)));
        directed.push_back(smp_row(3, RAW_TOP, 1, 0, 0));
        directed.push_back(smp_row(3, 0, 1, -FULL_SCALE, 0));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 29;
        recv_idle_pct = 61;
        foreach (directed[i]) begin
            row = directed[i];
            if (row.kind == ROW_CFG) begin
                drain();
                write_reg(row.idx, row.data);
            end else begin
                send_sample(row.slot, row.raw,
                            row.typed ? row.want : scale_sample(row.slot, row.raw));
            end
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            drain();
            case (p / 2)
                0: begin send_idle_pct = 29; recv_idle_pct = 61; end
                1: begin send_idle_pct = 61; recv_idle_pct = 29; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (p)
                0: write_reg(REG_DEADZONE, {CFG_W'({$urandom, $urandom})} & ~CFG_W'('h7F));
                1: write_reg(REG_DEADZONE, CFG_W'(PCT_MAX));
                2: write_reg(REG_DEADZONE, CFG_W'(127));
                default: write_reg(REG_DEADZONE,
                                   {CFG_W'({$urandom, $urandom}) & ~CFG_W'('h7F)}
                                   | CFG_W'($urandom_range(0, 127)));
            endcase
            for (int a = 0; a < CAL_REGS; a++)
                write_reg(CFG_IDX_W'(REG_CAL_BASE + a), random_cal());
            if ($urandom_range(0, 1))
                write_reg(CFG_IDX_W'($urandom_range(REG_NONE, 7)), CFG_W'({$urandom, $urandom}));

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                slot = SLOT_W'($urandom_range(0, CAL_REGS - 1));
                cal  = cal_mirror[slot];
                rest = int'(cal[CAL_REST_LSB +: CAL_W]);
                case ($urandom_range(0, 7))
                    0: raw = $urandom_range(0, 1) ? RAW_TOP : 0;
                    1: raw = rest + $urandom_range(0, 40) - 20;
                    2, 3: begin
                        // straddle the dead-zone boundary on a random side
                        side = $urandom_range(0, 1);
                        span = side ? int'(cal[CAL_MAX_LSB +: CAL_W]) - rest
                                    : rest - int'(cal[CAL_MIN_LSB +: CAL_W]);
                        dz   = (span > 0) ? span * ((dz_pct > PCT_MAX) ? int'(PCT_MAX)
                                                                       : int'(dz_pct)) / 100
                                          : 0;
                        dz   = dz + $urandom_range(0, 4) - 2;
                        raw  = side ? rest + dz : rest - dz;
                    end
                    default: raw = $urandom_range(0, RAW_TOP);
                endcase
                if (raw < 0)
                    raw = 0;
                if (raw > RAW_TOP)
                    raw = RAW_TOP;
                want = scale_sample(slot, RAW_W'(raw));
                send_sample(slot, RAW_W'(raw), want);
            end
        end

        drain();
        $display("sent %0d samples and checked %0d results over %0d register writes,",
                 samples_sent, results_seen, cfg_writes);
        $display("covering pass-through, dead zone 0 to 127, saturation and no-travel sides");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
